// ===== rtl/core/rbpi_pkg.sv =====
`timescale 1ns / 1ps
package rbpi_pkg;

  // Fixed settings of the integrator.
  localparam int CORDIC_STEPS  = 24;
  localparam int POS_FRAC_BITS = 16;
  localparam int NUM_CFG       = 7;

  // Configuration register indexes.
  localparam logic [2:0] CFG_POS_X  = 3'd0;
  localparam logic [2:0] CFG_POS_Y  = 3'd1;
  localparam logic [2:0] CFG_POS_Z  = 3'd2;
  localparam logic [2:0] CFG_QUAT_W = 3'd3;
  localparam logic [2:0] CFG_QUAT_X = 3'd4;
  localparam logic [2:0] CFG_QUAT_Y = 3'd5;
  localparam logic [2:0] CFG_QUAT_Z = 3'd6;

  localparam logic [31:0] QUAT_ONE  = 32'd1073741824;
  localparam logic [33:0] GAIN_Q30  = 34'd652032874;
  localparam logic [33:0] PI_Q30    = 34'd3373259426;
  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;

  // Input action codes.
  localparam logic ACT_INTEGRATE = 1'b0;
  localparam logic ACT_RELOAD    = 1'b1;

  typedef struct packed {
    logic               action;
    logic        [15:0] time_step;
    logic signed [31:0] lin_vel_x;
    logic signed [31:0] lin_vel_y;
    logic signed [31:0] lin_vel_z;
    logic signed [31:0] ang_vel_x;
    logic signed [31:0] ang_vel_y;
    logic signed [31:0] ang_vel_z;
  } rbpi_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } rbpi_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POS, ST_SQ, ST_CHK, ST_SQRT, ST_ANG, ST_MOD, ST_FOLD,
    ST_CORDIC, ST_AXMUL, ST_AXDIV, ST_QMUL, ST_QUPD, ST_DONE
  } rbpi_state_e;

  typedef enum logic {
    DS_DIV,
    DS_SQRT
  } rbpi_ds_op_e;

  typedef struct packed {
    logic        start;
    rbpi_ds_op_e op;
  } rbpi_ds_req_t;

  // Terms of the quaternion product that are subtracted, bit 4*j+k for
  // output part j and left operand part k.
  localparam logic [15:0] QP_NEG = 16'h428E;

  // Arctangent of 2^-i in Q.30, truncated toward zero.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd7;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rbpi_divsqrt.sv =====
`timescale 1ns / 1ps
// Bit-serial unsigned divider and square root sharing one subtractor.
// Division retires one quotient bit per cycle, square root one root bit
// per cycle.
module rbpi_divsqrt import rbpi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  rbpi_ds_req_t req_i,
  input  logic [63:0]  dividend_i,
  input  logic [33:0]  divisor_i,
  output logic         busy_o,
  output logic [63:0]  quot_o
);

  logic        busy_q;
  rbpi_ds_op_e op_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q;
  logic [33:0] den_q;
  logic [34:0] rem_q;
  logic [63:0] quot_q;

  logic [35:0] trial_a;
  logic [33:0] trial_b;
  logic [36:0] diff;
  logic        ge;
  logic [5:0]  last_cnt;

  // Shared trial subtraction.
  always_comb begin
    if (op_q == DS_DIV) begin
      trial_a = {rem_q, num_q[63]};
      trial_b = den_q;
    end else begin
      trial_a = {rem_q[33:0], num_q[63:62]};
      trial_b = {quot_q[31:0], 2'b01};
    end
    diff     = {1'b0, trial_a} - {3'b000, trial_b};
    ge       = ~diff[36];
    last_cnt = (op_q == DS_DIV) ? 6'd63 : 6'd31;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      op_q   <= DS_DIV;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      op_q   <= req_i.op;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == last_cnt) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q  <= dividend_i;
      den_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[34:0] : trial_a[34:0];
      quot_q <= {quot_q[62:0], ge};
      num_q  <= (op_q == DS_DIV) ? {num_q[62:0], 1'b0} : {num_q[61:0], 2'b00};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/core/rigid_body_pose_integrator.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      in_data_i   (rbpi_in_t)
// out       output     out_valid_o / out_ready_i    out_data_o  (rbpi_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// A reload request goes straight to the result; an integrate request with
// zero angular velocity updates only the position, otherwise it also runs
// 24 CORDIC steps. The bit-serial divider takes most of the time of such a
// request: three divisions for the axis parts plus a square root; the angle
// reduction is a run of compare and subtract steps.
// Reset is asynchronous, active low; it loads the pose from the register
// reset values. The block takes one request at a time: in_ready_o is low
// from acceptance until the result has been taken. cfg_ready_o is always high.
module rigid_body_pose_integrator import rbpi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rbpi_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output rbpi_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int HRS = (POS_FRAC_BITS > 13) ? POS_FRAC_BITS - 13 : 1;
  localparam int HLS = (POS_FRAC_BITS > 13) ? 0 : 13 - POS_FRAC_BITS;
  localparam logic [63:0] HRND = 64'd1 << (HRS - 1);
  // Width of the half angle and the highest shift of 2*pi that the
  // reduction has to try, since 2*pi is above 2^32.
  localparam int H_BITS  = (POS_FRAC_BITS > 13) ? 49 - HRS : 48 + HLS;
  localparam int MOD_TOP = (H_BITS > 33) ? H_BITS - 33 : 0;

  rbpi_state_e state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        ph_q, ph_d;
  logic        mul_en;
  rbpi_ds_req_t ds_req;

  rbpi_in_t           in_q;
  logic [31:0]        cfg_q [NUM_CFG];
  logic signed [31:0] pos_q [3];
  logic signed [31:0] quat_q [4];
  logic signed [31:0] qn_q [4];
  logic signed [32:0] r_q [3];
  logic        [63:0] sum_q;
  logic        [31:0] mag_q;
  logic signed [65:0] prod_q;
  logic signed [36:0] acc_q;
  logic signed [33:0] x_q, y_q;
  logic signed [34:0] z_q;
  logic               neg_q;
  logic        [63:0] mod_q;
  logic               out_valid_q;
  rbpi_out_t          out_q;

  logic               in_acc;
  logic [1:0]         idx;
  logic signed [31:0] v_sel, w_sel;
  logic signed [32:0] w_ext, aw;
  logic signed [33:0] cval, sval, as_full;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_d;
  logic [63:0]        h64, ds_dividend;
  logic [33:0]        ds_divisor;
  logic               ds_busy;
  logic [63:0]        ds_quot;
  logic [63:0]        mod_sub;
  logic               mod_ge;
  logic signed [34:0] z1, z2;
  logic               fold_neg;
  logic [1:0]         qj, qk, ridx;
  logic signed [32:0] rsel;
  logic signed [65:0] rnd66, dlt66;
  logic signed [36:0] term, acc_d, pos_sum;
  logic signed [32:0] axq;
  logic               ax_neg;

  assign in_acc      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Sequencer: next state, step counter, phase and unit strobes.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ph_d        = ph_q;
    mul_en      = 1'b0;
    ds_req      = '{start: 1'b0, op: DS_DIV};
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        ph_d  = 1'b0;
        if (in_acc) begin
          state_d = (in_data_i.action == ACT_RELOAD) ? ST_DONE : ST_POS;
        end
      end
      ST_POS, ST_SQ: begin
        mul_en = !ph_q;
        ph_d   = !ph_q;
        if (ph_q) begin
          if (cnt_q == 6'd2) begin
            cnt_d   = '0;
            state_d = (state_q == ST_POS) ? ST_SQ : ST_CHK;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      ST_CHK: begin
        ph_d    = 1'b0;
        state_d = (sum_q == 64'd0) ? ST_DONE : ST_SQRT;
      end
      ST_SQRT: begin
        if (!ph_q) begin
          ds_req = '{start: 1'b1, op: DS_SQRT};
          ph_d   = 1'b1;
        end else if (!ds_busy) begin
          ph_d    = 1'b0;
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        mul_en  = 1'b1;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        if (!ph_q) begin
          ph_d  = 1'b1;
          cnt_d = '0;
        end else if (cnt_q == 6'(MOD_TOP)) begin
          ph_d    = 1'b0;
          cnt_d   = '0;
          state_d = ST_FOLD;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_FOLD: begin
        cnt_d   = '0;
        state_d = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
          cnt_d   = '0;
          ph_d    = 1'b0;
          state_d = ST_AXMUL;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      ST_AXMUL: begin
        mul_en  = 1'b1;
        ph_d    = 1'b0;
        state_d = ST_AXDIV;
      end
      ST_AXDIV: begin
        if (!ph_q) begin
          ds_req = '{start: 1'b1, op: DS_DIV};
          ph_d   = 1'b1;
        end else if (!ds_busy) begin
          ph_d = 1'b0;
          if (cnt_q == 6'd2) begin
            cnt_d   = '0;
            state_d = ST_QMUL;
          end else begin
            cnt_d   = cnt_q + 6'd1;
            state_d = ST_AXMUL;
          end
        end
      end
      ST_QMUL: begin
        mul_en = !ph_q;
        ph_d   = !ph_q;
        if (ph_q) begin
          if (cnt_q == 6'd15) begin
            cnt_d   = '0;
            state_d = ST_QUPD;
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
      end
      ST_QUPD: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
    end
  end

  // Per-axis operand selection.
  assign idx = cnt_q[1:0];
  always_comb begin
    case (idx)
      2'd0: begin
        v_sel = in_q.lin_vel_x;
        w_sel = in_q.ang_vel_x;
      end
      2'd1: begin
        v_sel = in_q.lin_vel_y;
        w_sel = in_q.ang_vel_y;
      end
      default: begin
        v_sel = in_q.lin_vel_z;
        w_sel = in_q.ang_vel_z;
      end
    endcase
  end

  // Signed cos and sin after folding, and the axis magnitudes.
  always_comb begin
    w_ext   = {w_sel[31], w_sel};
    aw      = w_ext[32] ? -w_ext : w_ext;
    cval    = neg_q ? -x_q : x_q;
    sval    = neg_q ? -y_q : y_q;
    as_full = sval[33] ? -sval : sval;
    ax_neg  = w_sel[31] ^ sval[33];
    axq     = ds_quot[32:0];
    qj      = cnt_q[3:2];
    qk      = cnt_q[1:0];
    ridx    = qj ^ qk;
    rsel    = (ridx == 2'd0) ? cval[32:0] : r_q[ridx - 2'd1];
  end

  // Shared multiplier operand mux.
  always_comb begin
    case (state_q)
      ST_POS: begin
        mul_a = {v_sel[31], v_sel};
        mul_b = {17'd0, in_q.time_step};
      end
      ST_SQ: begin
        mul_a = w_ext;
        mul_b = w_ext;
      end
      ST_ANG: begin
        mul_a = {1'b0, mag_q};
        mul_b = {17'd0, in_q.time_step};
      end
      ST_AXMUL: begin
        mul_a = aw;
        mul_b = as_full[32:0];
      end
      ST_QMUL: begin
        mul_a = {quat_q[qk][31], quat_q[qk]};
        mul_b = rsel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // Half angle in Q.30, reduction step, and folding into [-pi/2, pi/2].
  always_comb begin
    if (POS_FRAC_BITS > 13) begin
      h64 = ({16'd0, prod_q[47:0]} + HRND) >> HRS;
    end else begin
      h64 = {16'd0, prod_q[47:0]} << HLS;
    end
    mod_sub = {30'd0, TWO_PI_Q30} << (6'(MOD_TOP) - cnt_q);
    mod_ge  = (mod_q >= mod_sub);
    z1 = ({1'b0, mod_q[33:0]} > {1'b0, PI_Q30})
           ? $signed({1'b0, mod_q[33:0]}) - $signed({1'b0, TWO_PI_Q30})
           : $signed({1'b0, mod_q[33:0]});
    fold_neg = 1'b0;
    z2       = z1;
    if (z1 > $signed({1'b0, HALF_PI_Q30})) begin
      z2       = z1 - $signed({1'b0, PI_Q30});
      fold_neg = 1'b1;
    end else if (z1 < -$signed({1'b0, HALF_PI_Q30})) begin
      z2       = z1 + $signed({1'b0, PI_Q30});
      fold_neg = 1'b1;
    end
  end

  // Divider operand mux.
  always_comb begin
    case (state_q)
      ST_SQRT: begin
        ds_dividend = sum_q;
        ds_divisor  = '0;
      end
      default: begin
        ds_dividend = prod_q[63:0];
        ds_divisor  = {2'b00, mag_q};
      end
    endcase
  end

  // Rounding of products and accumulation.
  always_comb begin
    rnd66   = prod_q + 66'sd536870912;
    term    = 37'(rnd66 >>> 30);
    acc_d   = ((qk == 2'd0) ? 37'sd0 : acc_q) + (QP_NEG[{qj, qk}] ? -term : term);
    dlt66   = (prod_q + 66'sd32768) >>> 16;
    pos_sum = {{5{pos_q[idx][31]}}, pos_q[idx]} + {{2{dlt66[34]}}, dlt66[34:0]};
  end

  rbpi_divsqrt u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ds_req),
    .dividend_i (ds_dividend),
    .divisor_i  (ds_divisor),
    .busy_o     (ds_busy),
    .quot_o     (ds_quot)
  );

  // Configuration registers and pose state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_q[i] <= (3'(i) == CFG_QUAT_W) ? QUAT_ONE : 32'd0;
      end
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
      end
      quat_q[0] <= QUAT_ONE;
      for (int i = 1; i < 4; i++) begin
        quat_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i < 3'(NUM_CFG))) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
      if (in_acc && in_data_i.action == ACT_RELOAD) begin
        pos_q[0]  <= cfg_q[CFG_POS_X];
        pos_q[1]  <= cfg_q[CFG_POS_Y];
        pos_q[2]  <= cfg_q[CFG_POS_Z];
        quat_q[0] <= cfg_q[CFG_QUAT_W];
        quat_q[1] <= cfg_q[CFG_QUAT_X];
        quat_q[2] <= cfg_q[CFG_QUAT_Y];
        quat_q[3] <= cfg_q[CFG_QUAT_Z];
      end
      if (state_q == ST_POS && ph_q) begin
        pos_q[idx] <= sat32(pos_sum);
      end
      if (state_q == ST_QUPD) begin
        for (int i = 0; i < 4; i++) begin
          quat_q[i] <= qn_q[i];
        end
      end
      if (state_q == ST_DONE) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
    if (mul_en) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_SQ && ph_q) begin
      sum_q <= ((cnt_q == 6'd0) ? 64'd0 : sum_q) + prod_q[63:0];
    end
    if (state_q == ST_SQRT && ph_q && !ds_busy) begin
      mag_q <= ds_quot[31:0];
    end
    // Angle reduction modulo 2*pi: load, then one shifted trial subtraction a cycle.
    if (state_q == ST_MOD) begin
      if (!ph_q) begin
        mod_q <= h64;
      end else if (mod_ge) begin
        mod_q <= mod_q - mod_sub;
      end
    end
    if (state_q == ST_FOLD) begin
      x_q   <= $signed(GAIN_Q30);
      y_q   <= '0;
      z_q   <= z2;
      neg_q <= fold_neg;
    end
    if (state_q == ST_CORDIC) begin
      if (!z_q[34]) begin
        x_q <= x_q - (y_q >>> cnt_q);
        y_q <= y_q + (x_q >>> cnt_q);
        z_q <= z_q - $signed({3'b000, atan_q30(cnt_q[4:0])});
      end else begin
        x_q <= x_q + (y_q >>> cnt_q);
        y_q <= y_q - (x_q >>> cnt_q);
        z_q <= z_q + $signed({3'b000, atan_q30(cnt_q[4:0])});
      end
    end
    if (state_q == ST_AXDIV && ph_q && !ds_busy) begin
      r_q[idx] <= ax_neg ? -axq : axq;
    end
    if (state_q == ST_QMUL && ph_q) begin
      acc_q <= acc_d;
      if (qk == 2'd3) begin
        qn_q[qj] <= sat32(acc_d);
      end
    end
    if (state_q == ST_DONE) begin
      out_q.pos_x  <= pos_q[0];
      out_q.pos_y  <= pos_q[1];
      out_q.pos_z  <= pos_q[2];
      out_q.quat_w <= quat_q[0];
      out_q.quat_x <= quat_q[1];
      out_q.quat_y <= quat_q[2];
      out_q.quat_z <= quat_q[3];
    end
  end

endmodule

// ===== rtl/core/rbpi_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the pose integrator.
module rbpi_checker import rbpi_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input rbpi_out_t   out_data_o,
  input logic        cfg_ready_o
);

  // A pending result holds its pose until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // Only one request is in flight: no new request while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("request taken while a result is pending");

  // A request closes the input until its result is delivered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o && !out_valid_o)
    else $error("input reopened right after a request");

  // Configuration writes are never stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port stalled");

endmodule

bind rigid_body_pose_integrator rbpi_checker u_rbpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);

// ===== verif/rigid_body_pose_integrator_tb.sv =====
`timescale 1ns / 1ps
module rigid_body_pose_integrator_tb;
  import rbpi_pkg::*;

  localparam int         CYCLE_LIMIT = 1_500_000;
  localparam int         RAND_ITEMS  = 150;
  // Index just past the register list; writes there must be dropped.
  localparam logic [2:0] CFG_UNUSED  = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  rbpi_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  rbpi_out_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  rigid_body_pose_integrator dut (.*);

  // Arctangent of 2^-i in Q.30, truncated toward zero.
  longint arctan_q30 [0:31] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 7, 3, 1, 0, 0};

  // Shadow registers and pose of the predictor.
  longint    start_regs [0:6];
  longint    pose_pos [0:2];
  longint    pose_quat [0:3];

  rbpi_in_t  pending_reqs [$];
  rbpi_out_t pose_expect_q [$];
  int        idle_pct;
  int        stall_pct;
  int        n_accepted;
  int        n_results;
  int        n_reloads;
  int        n_cfg_writes;
  int        n_errors;
  int        cycle_cnt;
  bit        send_now;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Q2.30 product rounded half up.
  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // Apply one request to the shadow pose and return the new pose.
  function automatic rbpi_out_t advance_pose(input rbpi_in_t req);
    longint            d, z, cx, sy, xs, ys, qv;
    longint            w [0:2];
    longint            r [0:3];
    longint            q [0:3];
    longint unsigned   sq, mag, h, aw, abs_s, dt;
    logic signed [31:0] lv [0:2];
    logic signed [31:0] av [0:2];
    bit                neg;
    rbpi_out_t         res;
    lv = '{req.lin_vel_x, req.lin_vel_y, req.lin_vel_z};
    av = '{req.ang_vel_x, req.ang_vel_y, req.ang_vel_z};
    dt = req.time_step;
    sq = 0;
    neg = 1'b0;
    if (req.action == ACT_RELOAD) begin
      for (int i = 0; i < 3; i++) pose_pos[i] = start_regs[i];
      for (int i = 0; i < 4; i++) pose_quat[i] = start_regs[3 + i];
    end else begin
      for (int i = 0; i < 3; i++) begin
        d = (longint'(lv[i]) * longint'(dt) + (64'sd1 <<< 15)) >>> 16;
        pose_pos[i] = clamp32(pose_pos[i] + d);
        w[i] = av[i];
        sq = sq + longint'(w[i] * w[i]);
      end
      // A zero angular velocity leaves the orientation alone.
      if (sq != 0) begin
        mag = int_sqrt(sq);
        h = (mag * dt + 4) >> 3;
        z = longint'(h % TWO_PI_Q30);
        if (z > longint'(PI_Q30)) z = z - longint'(TWO_PI_Q30);
        if (z > longint'(HALF_PI_Q30)) begin
          z = z - longint'(PI_Q30);
          neg = 1'b1;
        end else if (z < -longint'(HALF_PI_Q30)) begin
          z = z + longint'(PI_Q30);
          neg = 1'b1;
        end
        cx = longint'(GAIN_Q30);
        sy = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
          xs = cx >>> i;
          ys = sy >>> i;
          if (z >= 0) begin
            cx = cx - ys;
            sy = sy + xs;
            z = z - arctan_q30[i];
          end else begin
            cx = cx + ys;
            sy = sy - xs;
            z = z + arctan_q30[i];
          end
        end
        if (neg) begin
          cx = -cx;
          sy = -sy;
        end
        r[0] = cx;
        abs_s = (sy < 0) ? -sy : sy;
        for (int i = 0; i < 3; i++) begin
          aw = (w[i] < 0) ? -w[i] : w[i];
          qv = longint'((aw * abs_s) / mag);
          r[1 + i] = ((w[i] < 0) != (sy < 0)) ? -qv : qv;
        end
        for (int i = 0; i < 4; i++) q[i] = pose_quat[i];
        pose_quat[0] = clamp32(qmul(q[0], r[0]) - qmul(q[1], r[1])
                               - qmul(q[2], r[2]) - qmul(q[3], r[3]));
        pose_quat[1] = clamp32(qmul(q[0], r[1]) + qmul(q[1], r[0])
                               + qmul(q[2], r[3]) - qmul(q[3], r[2]));
        pose_quat[2] = clamp32(qmul(q[0], r[2]) - qmul(q[1], r[3])
                               + qmul(q[2], r[0]) + qmul(q[3], r[1]));
        pose_quat[3] = clamp32(qmul(q[0], r[3]) + qmul(q[1], r[2])
                               - qmul(q[2], r[1]) + qmul(q[3], r[0]));
      end
    end
    res.pos_x  = pose_pos[0][31:0];
    res.pos_y  = pose_pos[1][31:0];
    res.pos_z  = pose_pos[2][31:0];
    res.quat_w = pose_quat[0][31:0];
    res.quat_x = pose_quat[1][31:0];
    res.quat_y = pose_quat[2][31:0];
    res.quat_z = pose_quat[3][31:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      n_errors++;
    end
  endfunction

  // Request driver: presents queued requests and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      send_now = ($urandom_range(99) >= idle_pct) && (pending_reqs.size() != 0);
      if (in_valid_i && in_ready_o) begin
        pose_expect_q.push_back(advance_pose(in_data_i));
        n_accepted++;
        if (in_data_i.action == ACT_RELOAD) n_reloads++;
        if (send_now) in_data_i <= pending_reqs.pop_front();
        else in_valid_i <= 1'b0;
      end else if (!in_valid_i && send_now) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_reqs.pop_front();
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (pose_expect_q.size() == 0) begin
          $error("result with no request outstanding");
          n_errors++;
        end else begin
          check_field("pos_x", pose_expect_q[0].pos_x, out_data_o.pos_x);
          check_field("pos_y", pose_expect_q[0].pos_y, out_data_o.pos_y);
          check_field("pos_z", pose_expect_q[0].pos_z, out_data_o.pos_z);
          check_field("quat_w", pose_expect_q[0].quat_w, out_data_o.quat_w);
          check_field("quat_x", pose_expect_q[0].quat_x, out_data_o.quat_x);
          check_field("quat_y", pose_expect_q[0].quat_y, out_data_o.quat_y);
          check_field("quat_z", pose_expect_q[0].quat_z, out_data_o.quat_z);
          void'(pose_expect_q.pop_front());
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Shadow the register writes.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      n_cfg_writes++;
      if (cfg_index_i != CFG_UNUSED) start_regs[cfg_index_i] = longint'($signed(cfg_data_i));
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic push_req(input logic act, input logic [15:0] dt,
                          input logic [31:0] vx, vy, vz, wx, wy, wz);
    rbpi_in_t req;
    req.action    = act;
    req.time_step = dt;
    req.lin_vel_x = vx;
    req.lin_vel_y = vy;
    req.lin_vel_z = vz;
    req.ang_vel_x = wx;
    req.ang_vel_y = wy;
    req.ang_vel_z = wz;
    pending_reqs.push_back(req);
  endtask

  function automatic logic [31:0] rand_vel(input int kind);
    logic [31:0] v;
    case (kind)
      0: v = 32'd0;
      1: v = $urandom_range(32'h0010_0000) - 32'h0008_0000;
      2: v = ($urandom_range(1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic push_random_req();
    int          wkind;
    int          sel;
    logic [15:0] dt;
    sel = $urandom_range(99);
    wkind = $urandom_range(9);
    if (sel < 10) dt = 16'd0;
    else if (sel < 20) dt = 16'hFFFF;
    else if (sel < 50) dt = 16'($urandom_range(16'h0400));
    else dt = 16'($urandom);
    if ($urandom_range(99) < 8) begin
      push_req(ACT_RELOAD, 16'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
    end else if (wkind == 0) begin
      push_req(ACT_INTEGRATE, dt, rand_vel($urandom_range(3)), rand_vel($urandom_range(3)),
               rand_vel($urandom_range(3)), 32'd0, 32'd0, 32'd0);
    end else begin
      sel = (wkind < 5) ? 1 : ((wkind < 6) ? 2 : 3);
      push_req(ACT_INTEGRATE, dt, rand_vel($urandom_range(3)), rand_vel($urandom_range(3)),
               rand_vel($urandom_range(3)), rand_vel($urandom_range(3) == 0 ? 0 : sel),
               rand_vel(sel), rand_vel($urandom_range(3) == 0 ? 0 : sel));
    end
  endtask

  // Wait until every queued request has been answered.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || pose_expect_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Issue one register write; valid drops again once the write is taken.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_start_pose(input logic [31:0] px, py, pz, qw, qx, qy, qz);
    write_reg(CFG_POS_X, px);
    write_reg(CFG_POS_Y, py);
    write_reg(CFG_POS_Z, pz);
    write_reg(CFG_QUAT_W, qw);
    write_reg(CFG_QUAT_X, qx);
    write_reg(CFG_QUAT_Y, qy);
    write_reg(CFG_QUAT_Z, qz);
  endtask

  task automatic run_phase(input int idle_p, input int stall_p);
    idle_pct = idle_p;
    stall_pct = stall_p;
    push_req(ACT_RELOAD, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    for (int i = 0; i < RAND_ITEMS; i++) push_random_req();
    wait_drained();
  endtask

  initial begin
    start_regs = '{0, 0, 0, 1073741824, 0, 0, 0};
    pose_pos   = '{0, 0, 0};
    pose_quat  = '{1073741824, 0, 0, 0};
    idle_pct = 0;
    stall_pct = 0;
    n_accepted = 0;
    n_results = 0;
    n_reloads = 0;
    n_cfg_writes = 0;
    n_errors = 0;
    cycle_cnt = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_POS_X;
    cfg_data_i = 32'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests from the reset pose.
    push_req(ACT_INTEGRATE, 16'h8000, 32'h0001_0000, 32'hFFFF_0000, 32'd0,
             32'd0, 32'd0, 32'd0);
    push_req(ACT_INTEGRATE, 16'd0, 32'd5, 32'd6, 32'd7, 32'h0001_0000, 32'd0, 32'd0);
    push_req(ACT_INTEGRATE, 16'h1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0003_0000, 32'd0);
    push_req(ACT_INTEGRATE, 16'hFFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFD_0000);
    push_req(ACT_INTEGRATE, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(ACT_INTEGRATE, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_req(ACT_INTEGRATE, 16'hC000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
             32'h0004_0000, 32'h0004_0000, 32'd0);
    push_req(ACT_INTEGRATE, 16'h0001, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0);
    push_req(ACT_INTEGRATE, 16'h4000, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(ACT_RELOAD, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(ACT_INTEGRATE, 16'h2000, 32'h0002_8000, 32'hFFFE_8000, 32'h0000_8000,
             32'h0006_4000, 32'h0000_0000, 32'hFFFC_0000);
    wait_drained();

    // Extreme start values, then a register index past the list.
    write_start_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_reg(CFG_UNUSED, 32'h1234_5678);
    push_req(ACT_RELOAD, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_req(ACT_INTEGRATE, 16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    push_req(ACT_INTEGRATE, 16'h0100, 32'd0, 32'd0, 32'd0, 32'hFFFF_0000, 32'd0, 32'd0);
    wait_drained();
    write_start_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_req(ACT_RELOAD, 16'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_req(ACT_INTEGRATE, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
    wait_drained();

    // Random phases, each from a different start pose.
    write_start_pose(32'd0, 32'd0, 32'd0, QUAT_ONE, 32'd0, 32'd0, 32'd0);
    run_phase(0, 0);
    write_start_pose($urandom, $urandom, $urandom, 32'h2D41_3CCD, 32'h2D41_3CCD,
                     32'd0, 32'd0);
    run_phase(75, 0);
    write_start_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_phase(0, 75);
    write_start_pose(32'h0100_0000, 32'hFF00_0000, 32'd0, 32'h2000_0000, 32'h2000_0000,
                     32'h2000_0000, 32'h2000_0000);
    run_phase(20, 20);

    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests (%0d reloads), %0d results, %0d register writes.",
             n_accepted, n_reloads, n_results, n_cfg_writes);
    if (n_errors == 0 && pose_expect_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (pose_expect_q.size() != 0) $error("%0d results never arrived", pose_expect_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
